// ----- rtl/bfsam_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsam_pkg
// Shared widths, opcodes and state codes for the BFS adjacency-matrix block.
// ----------------------------------------------------------------------------
package bfsam_pkg;

    localparam int MAX_VERTEX = 64;
    localparam int VTX_W      = $clog2(MAX_VERTEX);
    localparam int CNT_W      = $clog2(MAX_VERTEX + 1);
    localparam int ROW_W      = MAX_VERTEX;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } t_opcode;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FIFO = 6'b000010,
        S_ROW  = 6'b000100,
        S_SCAN = 6'b001000,
        S_EMIT = 6'b010000,
        S_ERR  = 6'b100000
    } t_state;

endpackage

// ----- rtl/bfsam_in_if.sv -----
// ----------------------------------------------------------------------------
// bfsam_in_if
// Input word channel: load one adjacency row or start a traversal.
// ----------------------------------------------------------------------------
interface bfsam_in_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [bfsam_pkg::VTX_W-1:0]    vertex;
    logic [bfsam_pkg::ROW_W-1:0]    row_bits;

    modport source (output valid, opcode, vertex, row_bits, input ready);
    modport sink   (input valid, opcode, vertex, row_bits, output ready);
endinterface

// ----- rtl/bfsam_out_if.sv -----
// ----------------------------------------------------------------------------
// bfsam_out_if
// Result word channel: one visited vertex per word.
// ----------------------------------------------------------------------------
interface bfsam_out_if;
    logic                           valid;
    logic                           ready;
    logic [bfsam_pkg::VTX_W-1:0]    visited_vertex;
    logic                           last;
    logic                           error;

    modport source (output valid, visited_vertex, last, error, input ready);
    modport sink   (input valid, visited_vertex, last, error, output ready);
endinterface

// ----- rtl/bfsam_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bfsam_cfg_if
// Configuration write channel for the vertex count register.
// ----------------------------------------------------------------------------
interface bfsam_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bfsam_pkg::CNT_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/bfs_adjacency_matrix.sv -----
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix
// Breadth-first traversal over an adjacency bit matrix held in RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-----------------------------------------
//  i_in     | in  | valid/ready  | opcode, vertex, row_bits
//  o_out    | out | valid/ready  | visited_vertex, last, error
//  i_cfg    | in  | valid/ready  | data = vertex_count (7 bits)
//
//  A load writes its row into the adjacency RAM. After a run is accepted,
//  each dequeued vertex takes RAM reads (queue entry, then adjacency row),
//  one scan step per newly found neighbor plus one that finds none left,
//  and one emit step to hand the word to the output register. An out-of-range
//  start goes to the error state and gives one error word.
//  Reset clears control state and sets vertex_count to 64; RAMs are not
//  cleared. A stalled output holds the traversal in the emit state.
// ----------------------------------------------------------------------------
module bfs_adjacency_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfsam_in_if.sink      i_in,
    bfsam_out_if.source   o_out,
    bfsam_cfg_if.sink     i_cfg
);

    localparam int VW = bfsam_pkg::VTX_W;
    localparam int CW = bfsam_pkg::CNT_W;
    localparam int RW = bfsam_pkg::ROW_W;

    bfsam_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count;
    logic [RW-1:0] r_visited, n_visited;
    logic [CW-1:0] r_head, n_head;
    logic [CW-1:0] r_tail, n_tail;
    logic [VW-1:0] r_node, n_node;

    logic          r_out_valid;
    logic [VW-1:0] r_out_vertex;
    logic          r_out_last;
    logic          r_out_error;

    logic [CW-1:0] eff_count;
    logic [RW-1:0] scan_mask;
    logic [RW-1:0] pend;
    logic [VW-1:0] pick;
    logic          out_free;
    logic          in_fire;
    logic          is_run;
    logic          start_ok;

    // adjacency RAM ports
    logic          adj_we;
    logic          adj_re;
    logic [RW-1:0] adj_rdata;

    // queue RAM ports
    logic          q_we;
    logic [VW-1:0] q_waddr;
    logic [VW-1:0] q_wdata;
    logic          q_re;
    logic [VW-1:0] q_rdata;

    function automatic logic [VW-1:0] first_set(input logic [RW-1:0] v);
        logic [VW-1:0] f;
        f = '0;
        for (int i = RW - 1; i >= 0; i--) begin
            if (v[i]) begin
                f = VW'(i);
            end
        end
        return f;
    endfunction

    assign eff_count = (r_count > CW'(bfsam_pkg::MAX_VERTEX))
                     ? CW'(bfsam_pkg::MAX_VERTEX) : r_count;

    always_comb begin
        for (int i = 0; i < RW; i++) begin
            scan_mask[i] = (CW'(i) < eff_count);
        end
    end

    assign pend     = adj_rdata & ~r_visited & scan_mask;
    assign pick     = first_set(pend);
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready = (r_state == bfsam_pkg::S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign is_run     = (i_in.opcode == bfsam_pkg::OP_RUN);
    assign start_ok   = ({1'b0, i_in.vertex} < eff_count);

    assign i_cfg.ready = 1'b1;

    assign adj_we = in_fire && !is_run;
    assign adj_re = (r_state == bfsam_pkg::S_ROW);

    bfsam_ram #(
        .WIDTH (RW),
        .DEPTH (bfsam_pkg::MAX_VERTEX)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (i_in.vertex),
        .i_wdata (i_in.row_bits),
        .i_re    (adj_re),
        .i_raddr (q_rdata),
        .o_rdata (adj_rdata)
    );

    bfsam_ram #(
        .WIDTH (VW),
        .DEPTH (bfsam_pkg::MAX_VERTEX)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (r_head[VW-1:0]),
        .o_rdata (q_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_visited = r_visited;
        n_head    = r_head;
        n_tail    = r_tail;
        n_node    = r_node;
        q_we      = 1'b0;
        q_waddr   = r_tail[VW-1:0];
        q_wdata   = pick;
        q_re      = 1'b0;

        unique case (r_state)
            bfsam_pkg::S_IDLE: begin
                if (in_fire && is_run) begin
                    if (start_ok) begin
                        // seed the queue with the start vertex
                        q_we      = 1'b1;
                        q_waddr   = '0;
                        q_wdata   = i_in.vertex;
                        n_visited = RW'(1) << i_in.vertex;
                        n_head    = '0;
                        n_tail    = CW'(1);
                        n_state   = bfsam_pkg::S_FIFO;
                    end else begin
                        n_state = bfsam_pkg::S_ERR;
                    end
                end
            end
            bfsam_pkg::S_FIFO: begin
                q_re    = 1'b1;
                n_state = bfsam_pkg::S_ROW;
            end
            bfsam_pkg::S_ROW: begin
                n_node  = q_rdata;
                n_head  = r_head + CW'(1);
                n_state = bfsam_pkg::S_SCAN;
            end
            bfsam_pkg::S_SCAN: begin
                // one unvisited neighbor per cycle, lowest index first
                if (pend != '0) begin
                    q_we            = 1'b1;
                    n_visited[pick] = 1'b1;
                    n_tail          = r_tail + CW'(1);
                end else begin
                    n_state = bfsam_pkg::S_EMIT;
                end
            end
            bfsam_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = (r_head == r_tail) ? bfsam_pkg::S_IDLE : bfsam_pkg::S_FIFO;
                end
            end
            bfsam_pkg::S_ERR: begin
                if (out_free) begin
                    n_state = bfsam_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfsam_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bfsam_pkg::S_IDLE;
            r_count   <= CW'(bfsam_pkg::MAX_VERTEX);
            r_visited <= '0;
            r_head    <= '0;
            r_tail    <= '0;
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_head    <= n_head;
            r_tail    <= n_tail;
            if (i_cfg.valid && i_cfg.ready) begin
                r_count <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_free && (r_state == bfsam_pkg::S_EMIT || r_state == bfsam_pkg::S_ERR)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_state == bfsam_pkg::S_EMIT) begin
            r_out_vertex <= r_node;
            r_out_last   <= (r_head == r_tail);
            r_out_error  <= 1'b0;
        end else if (out_free && r_state == bfsam_pkg::S_ERR) begin
            r_out_vertex <= '0;
            r_out_last   <= 1'b1;
            r_out_error  <= 1'b1;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.visited_vertex = r_out_vertex;
    assign o_out.last           = r_out_last;
    assign o_out.error          = r_out_error;

endmodule

// ----- rtl/bfsam_ram.sv -----
// ----------------------------------------------------------------------------
// bfsam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BFS adjacency-matrix block: rows are loaded,
// traversals are started under several vertex counts, and every visited word
// is checked against a BFS order predicted inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import bfsam_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS = 27;

    typedef struct packed {
        logic [VTX_W-1:0] vtx;
        logic             last;
        logic             err;
    } visit_word_t;

    // Holds the graph, the active count and the visit words still owed.
    class bfs_order_tracker;
        logic [ROW_W-1:0]      adj_rows [MAX_VERTEX];
        logic [MAX_VERTEX-1:0] loaded;
        int unsigned           active_cnt;
        visit_word_t           pending_visits [$];
        int unsigned           mismatches;

        function new();
            loaded     = '0;
            active_cnt = MAX_VERTEX;
            mismatches = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] data);
            active_cnt = (data > MAX_VERTEX) ? MAX_VERTEX : data;
        endfunction

        function void trace_bfs(int unsigned start, output int unsigned order [$]);
            logic [MAX_VERTEX-1:0] seen;
            int unsigned           head;
            int unsigned           node;
            int unsigned           i;
            order.delete();
            seen        = '0;
            head        = 0;
            seen[start] = 1'b1;
            order.push_back(start);
            while (head < order.size()) begin
                node = order[head];
                head++;
                for (i = 0; i < active_cnt; i++) begin
                    if (adj_rows[node][i] === 1'b1 && !seen[i]) begin
                        seen[i] = 1'b1;
                        order.push_back(i);
                    end
                end
            end
        endfunction

        // A run may only touch rows that were loaded; report the first one missing.
        function bit find_unloaded(int unsigned start, output int unsigned vtx);
            int unsigned order [$];
            trace_bfs(start, order);
            foreach (order[k]) begin
                if (!loaded[order[k]]) begin
                    vtx = order[k];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_input(t_opcode op, logic [VTX_W-1:0] v, logic [ROW_W-1:0] row);
            int unsigned order [$];
            visit_word_t w;
            if (op == OP_LOAD) begin
                adj_rows[v] = row;
                loaded[v]   = 1'b1;
                return;
            end
            if (v >= active_cnt) begin
                w.vtx  = '0;
                w.last = 1'b1;
                w.err  = 1'b1;
                pending_visits.push_back(w);
                return;
            end
            trace_bfs(v, order);
            foreach (order[k]) begin
                w.vtx  = VTX_W'(order[k]);
                w.last = (k == order.size() - 1);
                w.err  = 1'b0;
                pending_visits.push_back(w);
            end
        endfunction

        function void check_result(visit_word_t got);
            visit_word_t want;
            if (pending_visits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: vertex=%0d last=%0b error=%0b",
                             got.vtx, got.last, got.err);
                return;
            end
            want = pending_visits.pop_front();
            if (got.vtx !== want.vtx || got.last !== want.last || got.err !== want.err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected vertex=%0d last=%0b error=%0b,",
                              " got vertex=%0d last=%0b error=%0b"},
                             want.vtx, want.last, want.err, got.vtx, got.last, got.err);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    bit               idle_en = 1'b1;
    int unsigned      cycles = 0;
    bfs_order_tracker sb;

    bfsam_in_if  in_if ();
    bfsam_out_if out_if ();
    bfsam_cfg_if cfg_if ();

    bfs_adjacency_matrix dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(visit_word_t'{vtx: out_if.visited_vertex,
                                          last: out_if.last, err: out_if.error});
    end

    // Output back-pressure in random bursts, stall or not.
    initial begin
        int unsigned hold;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            hold = $urandom_range(1, 8);
            out_if.ready <= idle_en ? ($urandom_range(0, 2) != 0) : 1'b1;
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    function automatic logic [ROW_W-1:0] make_row();
        logic [ROW_W-1:0] r;
        case ($urandom_range(0, 5))
            0: r = {$urandom, $urandom};
            1: r = '0;
            2: r = '1;
            default: begin
                // sparse rows give long, many-level traversals
                r = '0;
                repeat ($urandom_range(1, 3)) r[$urandom_range(0, MAX_VERTEX - 1)] = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_word(t_opcode op, logic [VTX_W-1:0] v, logic [ROW_W-1:0] row);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.opcode   <= op;
        in_if.vertex   <= v;
        in_if.row_bits <= row;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(op, v, row);
        @(negedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.set_count(data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop the input and wait until the block has drained and gone idle.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.pending_visits.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_item();
        int unsigned start;
        int unsigned miss;
        int unsigned cnt;
        cnt = sb.active_cnt;
        if ($urandom_range(0, 99) < 30) begin
            send_word(OP_LOAD, VTX_W'($urandom_range(0, MAX_VERTEX - 1)), make_row());
        end else if (cnt == 0 || (cnt < MAX_VERTEX && $urandom_range(0, 99) < 12)) begin
            send_word(OP_RUN, VTX_W'($urandom_range(cnt, MAX_VERTEX - 1)),
                      {$urandom, $urandom});
        end else begin
            start = $urandom_range(0, cnt - 1);
            if (sb.find_unloaded(start, miss))
                send_word(OP_LOAD, VTX_W'(miss), make_row());
            else
                send_word(OP_RUN, VTX_W'(start), {$urandom, $urandom});
        end
    endtask

    initial begin
        logic [CNT_W-1:0] cnt;
        sb = new();
        in_if.valid    = 1'b0;
        in_if.opcode   = OP_LOAD;
        in_if.vertex   = '0;
        in_if.row_bits = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset count of 64: isolated vertex, self loop, small graph
        send_word(OP_LOAD, 0, '0);
        send_word(OP_RUN, 0, '1);
        send_word(OP_LOAD, 63, {1'b1, 62'b0, 1'b1});
        send_word(OP_RUN, 63, '0);
        send_word(OP_LOAD, 1, 64'h0000_0000_0000_000C);
        send_word(OP_LOAD, 2, 64'h0000_0000_0000_0010);
        send_word(OP_LOAD, 3, 64'h0000_0000_0000_0012);
        send_word(OP_LOAD, 4, 64'h8000_0000_0000_0000);
        send_word(OP_RUN, 1, 64'h5555_5555_5555_5555);
        settle();
        // count of zero: every start is out of range
        write_count(7'd0);
        send_word(OP_RUN, 0, '0);
        send_word(OP_RUN, 63, '1);
        settle();
        // count above the maximum saturates
        write_count(7'd127);
        send_word(OP_RUN, 63, '0);
        settle();
        // count of one: row bits above the count are never scanned
        write_count(7'd1);
        send_word(OP_LOAD, 0, '1);
        send_word(OP_RUN, 0, '0);
        send_word(OP_RUN, 1, '0);
        settle();
        write_count(7'd5);
        send_word(OP_RUN, 1, '0);
        send_word(OP_RUN, 5, '0);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       cnt = 7'd64;
                1:       cnt = CNT_W'($urandom_range(2, 63));
                2:       cnt = 7'd127;
                3:       cnt = 7'd0;
                4:       cnt = CNT_W'($urandom_range(1, 64));
                default: cnt = 7'd64;
            endcase
            write_count(cnt);
            idle_en = (p != 5);
            repeat (PHASE_ITEMS) random_item();
            settle();
        end

        repeat (16) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_visits.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
